// ----- rtl/core/sfcd_pkg.sv -----
package sfcd_pkg;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;
	localparam logic [15:0] MAG_MASK = 16'h7FFF;
	localparam logic [15:0] SIGN_BIT = 16'h8000;
	localparam int PAYLOAD_N = 4;

	// Byte positions within the frame.
	localparam logic [2:0] IDX_PAY_FIRST = 3'd2;
	localparam logic [2:0] IDX_PAY_LAST  = 3'd5;
	localparam logic [2:0] IDX_CRC_LO    = 3'd6;
	localparam logic [2:0] IDX_CRC_HI    = 3'd7;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       frame_start;
	} item_t;

	typedef struct packed {
		logic               crc_ok;
		logic        [15:0] humidity_tenths;
		logic signed [15:0] temperature_tenths;
	} result_t;

	// One byte of CRC-16/MODBUS, reflected, least significant bit first.
	function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

// ----- rtl/core/sensor_frame_crc_decoder.sv -----
// A result is offered from the output register once frame byte 7 has left the input register.
// Throughput: one byte per cycle outside the stall below; each byte's CRC update is eight unrolled
// shift-and-XOR steps between the input register and the frame state, so bytes stream without gaps.
// A result waiting in the output register stalls input only while byte 7 sits in the input register.
// Reset (arst_n, asynchronous, active low) clears the frame count, sets the CRC to 0xFFFF
// and empties the input and output registers.
module sensor_frame_crc_decoder (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  sfcd_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_ready,
	output sfcd_pkg::result_t result
);

	logic              valid_s1;
	sfcd_pkg::item_t   item_s1;
	logic              result_valid_q;
	sfcd_pkg::result_t result_q;

	logic              last;
	logic              out_free;
	logic              s1_go;
	sfcd_pkg::result_t engine_result;

	sfcd_frame_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (s1_go),
		.item   (item_s1),
		.last   (last),
		.result (engine_result)
	);

	// Only a byte that closes a frame needs room in the output register.
	assign out_free   = !result_valid_q || result_ready;
	assign s1_go      = valid_s1 && (!last || out_free);
	assign item_ready = !valid_s1 || s1_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (item_ready) begin
				valid_s1 <= item_valid;
			end
			if (s1_go && last) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1 <= item;
		end
		if (s1_go && last) begin
			result_q <= engine_result;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

// ----- rtl/core/sfcd_frame_engine.sv -----
module sfcd_frame_engine (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  sfcd_pkg::item_t   item,
	output logic              last,
	output sfcd_pkg::result_t result
);

	localparam logic [1:0] IDX_OFFSET = sfcd_pkg::IDX_PAY_FIRST[1:0];

	logic [2:0]  index_q;
	logic [15:0] crc_q;
	logic [7:0]  payload_q [sfcd_pkg::PAYLOAD_N];
	logic [7:0]  crc_lo_q;

	logic [2:0]  idx;
	logic [15:0] crc_base;
	logic [1:0]  payload_sel;
	logic [15:0] rx_crc;
	logic [15:0] hum_raw;
	logic [15:0] temp_word;
	logic [15:0] temp_mag;
	logic [15:0] temp_twos;
	logic        ok;

	// A start flag restarts the count and the CRC before the byte is taken.
	assign idx         = item.frame_start ? 3'd0 : index_q;
	assign crc_base    = item.frame_start ? sfcd_pkg::CRC_INIT : crc_q;
	assign payload_sel = idx[1:0] - IDX_OFFSET;
	assign last        = (idx == sfcd_pkg::IDX_CRC_HI);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			index_q <= 3'd0;
			crc_q   <= sfcd_pkg::CRC_INIT;
		end else if (step) begin
			index_q <= idx + 3'd1;
			if (idx <= sfcd_pkg::IDX_PAY_LAST) begin
				crc_q <= sfcd_pkg::crc_feed(crc_base, item.rx_byte);
			end else if (last) begin
				crc_q <= sfcd_pkg::CRC_INIT;
			end else begin
				crc_q <= crc_base;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step && idx >= sfcd_pkg::IDX_PAY_FIRST && idx <= sfcd_pkg::IDX_PAY_LAST) begin
			payload_q[payload_sel] <= item.rx_byte;
		end
		if (step && idx == sfcd_pkg::IDX_CRC_LO) begin
			crc_lo_q <= item.rx_byte;
		end
	end

	assign rx_crc    = {item.rx_byte, crc_lo_q};
	assign ok        = (rx_crc == crc_q);
	assign hum_raw   = {payload_q[0], payload_q[1]};
	assign temp_word = {payload_q[2], payload_q[3]};
	assign temp_mag  = temp_word & sfcd_pkg::MAG_MASK;
	// Sign-magnitude to two's complement; negative zero comes out as zero.
	assign temp_twos = ((temp_word & sfcd_pkg::SIGN_BIT) != 16'h0000) ? (16'h0000 - temp_mag)
	                                                                  : temp_mag;

	always_comb begin
		result.crc_ok             = ok;
		result.humidity_tenths    = ok ? hum_raw : 16'h0000;
		result.temperature_tenths = ok ? $signed(temp_twos) : 16'sh0000;
	end

endmodule

// ----- rtl/core/sfcd_checker.sv -----
module sfcd_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              item_valid,
	input logic              item_ready,
	input sfcd_pkg::item_t   item,
	input logic              result_valid,
	input logic              result_ready,
	input sfcd_pkg::result_t result
);

	// A result transaction stays offered until it is taken.
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid)
		else $error("result withdrawn before it was taken");

	a_result_stable: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> $stable(result))
		else $error("result payload changed while stalled");

	// A failed check must not leak stale readings.
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.crc_ok |->
			result.humidity_tenths == 16'h0000 && result.temperature_tenths == 16'sh0000)
		else $error("readings not cleared on CRC failure");

	// Sign-magnitude input can never produce the most negative code.
	a_temp_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.temperature_tenths != 16'sh8000)
		else $error("temperature out of sign-magnitude range");

endmodule

bind sensor_frame_crc_decoder sfcd_checker u_sfcd_checker (.*);
